>>> rtl/chacha8_state_dependent_keystream_unit_assert.svh
// Assertion macros shared by the keystream unit RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef CHACHA8_STATE_DEPENDENT_KEYSTREAM_UNIT_ASSERT_SVH
`define CHACHA8_STATE_DEPENDENT_KEYSTREAM_UNIT_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every rising edge outside reset.
`define CSK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define CSK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define CSK_ASSERT(lbl, prop, msg)
`define CSK_NEVER(lbl, cond, msg)

`endif

`endif

>>> rtl/csk_pkg.sv
// Shared types, constants and helper functions of the keystream unit.
// No dependencies; used by csk_qr_step and the top level.
package csk_pkg;

  // Configuration port.
  localparam int unsigned NumCfgRegs      = 8;
  localparam int unsigned CfgIdxW         = 4;
  localparam int unsigned CfgSelW         = 3;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned RegNonce        = 6;
  localparam int unsigned RegCounterStart = 7;

  // Block layout: sixteen words as a 4x4 matrix, pairs of words per register.
  localparam int unsigned WordW       = 32;
  localparam int unsigned NumWords    = 16;
  localparam int unsigned WordIdxW    = 4;
  localparam int unsigned NumPairs    = 8;
  localparam int unsigned CounterPair = 6;
  localparam logic [WordIdxW-1:0] WordIdxLast = WordIdxW'(NumWords - 1);

  // Round structure.
  localparam int unsigned NumDoubleRounds = 4;
  localparam logic [1:0]  LastRound       = 2'(NumDoubleRounds - 1);

  // Rotation constants and the Barrett reduction by 31.
  localparam int unsigned RotB        = 12;
  localparam int unsigned RotC        = 8;
  localparam int unsigned RotD        = 7;
  localparam int unsigned BarrettMul   = 265;
  localparam int unsigned BarrettShift = 13;
  localparam int unsigned RotModulus   = 31;

  // Micro-program counter.
  localparam int unsigned PcW = 6;
  localparam logic [PcW-1:0] PcWait = PcW'(0);
  localparam logic [PcW-1:0] PcBody = PcW'(1);
  localparam logic [PcW-1:0] PcLoop = PcW'(33);
  localparam logic [PcW-1:0] PcEmit = PcW'(34);

  typedef enum logic [2:0] {
    OP_WAIT,  // take an input beat
    OP_AD,    // a += b; d = rotl(d ^ a, rot)
    OP_CB,    // c += d; b = rotl(b ^ c, rot)
    OP_LOOP,  // count double rounds, jump back to the body until the last
    OP_EMIT   // add back the input words, one output beat per cycle unless the output stalls
  } op_e;

  typedef enum logic [1:0] {
    ROT_DYN,
    ROT_12,
    ROT_8,
    ROT_7
  } rot_e;

  // Row rotation of the state matrix applied after a step.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_COL,     // next column moves into column 0
    SH_DIAG,    // next column, then diagonals into columns
    SH_UNDIAG   // next column, then diagonals back into rows
  } shift_e;

  typedef struct packed {
    op_e              op;
    rot_e             rot;
    shift_e           shift;
    logic [PcW-1:0]   target;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    rot_e rot;
  } qr_ctl_t;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } qr_words_t;

  // Micro-program ROM. Each quarter-round is four steps on column 0 of the
  // state matrix; the last step of each quarter-round rotates the rows.
  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t uc;
    uc = '{OP_WAIT, ROT_DYN, SH_NONE, PcWait};
    case (pc)
      6'd0:  uc = '{OP_WAIT, ROT_DYN, SH_NONE,   PcWait};
      // Column quarter-rounds.
      6'd1:  uc = '{OP_AD,   ROT_DYN, SH_NONE,   PcWait};
      6'd2:  uc = '{OP_CB,   ROT_12,  SH_NONE,   PcWait};
      6'd3:  uc = '{OP_AD,   ROT_8,   SH_NONE,   PcWait};
      6'd4:  uc = '{OP_CB,   ROT_7,   SH_COL,    PcWait};
      6'd5:  uc = '{OP_AD,   ROT_DYN, SH_NONE,   PcWait};
      6'd6:  uc = '{OP_CB,   ROT_12,  SH_NONE,   PcWait};
      6'd7:  uc = '{OP_AD,   ROT_8,   SH_NONE,   PcWait};
      6'd8:  uc = '{OP_CB,   ROT_7,   SH_COL,    PcWait};
      6'd9:  uc = '{OP_AD,   ROT_DYN, SH_NONE,   PcWait};
      6'd10: uc = '{OP_CB,   ROT_12,  SH_NONE,   PcWait};
      6'd11: uc = '{OP_AD,   ROT_8,   SH_NONE,   PcWait};
      6'd12: uc = '{OP_CB,   ROT_7,   SH_COL,    PcWait};
      6'd13: uc = '{OP_AD,   ROT_DYN, SH_NONE,   PcWait};
      6'd14: uc = '{OP_CB,   ROT_12,  SH_NONE,   PcWait};
      6'd15: uc = '{OP_AD,   ROT_8,   SH_NONE,   PcWait};
      6'd16: uc = '{OP_CB,   ROT_7,   SH_DIAG,   PcWait};
      // Diagonal quarter-rounds.
      6'd17: uc = '{OP_AD,   ROT_DYN, SH_NONE,   PcWait};
      6'd18: uc = '{OP_CB,   ROT_12,  SH_NONE,   PcWait};
      6'd19: uc = '{OP_AD,   ROT_8,   SH_NONE,   PcWait};
      6'd20: uc = '{OP_CB,   ROT_7,   SH_COL,    PcWait};
      6'd21: uc = '{OP_AD,   ROT_DYN, SH_NONE,   PcWait};
      6'd22: uc = '{OP_CB,   ROT_12,  SH_NONE,   PcWait};
      6'd23: uc = '{OP_AD,   ROT_8,   SH_NONE,   PcWait};
      6'd24: uc = '{OP_CB,   ROT_7,   SH_COL,    PcWait};
      6'd25: uc = '{OP_AD,   ROT_DYN, SH_NONE,   PcWait};
      6'd26: uc = '{OP_CB,   ROT_12,  SH_NONE,   PcWait};
      6'd27: uc = '{OP_AD,   ROT_8,   SH_NONE,   PcWait};
      6'd28: uc = '{OP_CB,   ROT_7,   SH_COL,    PcWait};
      6'd29: uc = '{OP_AD,   ROT_DYN, SH_NONE,   PcWait};
      6'd30: uc = '{OP_CB,   ROT_12,  SH_NONE,   PcWait};
      6'd31: uc = '{OP_AD,   ROT_8,   SH_NONE,   PcWait};
      6'd32: uc = '{OP_CB,   ROT_7,   SH_UNDIAG, PcWait};
      // Double-round loop and output.
      6'd33: uc = '{OP_LOOP, ROT_DYN, SH_NONE,   PcBody};
      6'd34: uc = '{OP_EMIT, ROT_DYN, SH_NONE,   PcWait};
      default: uc = '{OP_WAIT, ROT_DYN, SH_NONE, PcWait};
    endcase
    return uc;
  endfunction

  // Left rotation amount of one matrix row for a shift code.
  function automatic logic [1:0] row_shift_amt(shift_e sh, logic [1:0] row);
    logic [1:0] amt;
    case (sh)
      SH_NONE:   amt = 2'd0;
      SH_COL:    amt = 2'd1;
      SH_DIAG:   amt = row + 2'd1;
      SH_UNDIAG: amt = 2'd1 - row;
      default:   amt = 2'd0;
    endcase
    return amt;
  endfunction

  // Exact x mod 31 for an 8-bit x: q = (x * 265) >> 13, r = x - 31 * q.
  function automatic logic [4:0] mod31(logic [7:0] x);
    logic [16:0] prod;
    logic [3:0]  q;
    logic [8:0]  qm;
    logic [8:0]  r;
    prod = 17'(x) * 17'(BarrettMul);
    q    = 4'(prod >> BarrettShift);
    qm   = 9'(q) * 9'(RotModulus);
    r    = 9'(x) - qm;
    return r[4:0];
  endfunction

  // 32-bit left rotation by 0..31.
  function automatic logic [WordW-1:0] rotl(logic [WordW-1:0] v, logic [4:0] n);
    logic [2*WordW-1:0] t;
    t = {v, v} << n;
    return t[2*WordW-1:WordW];
  endfunction

endpackage

>>> rtl/csk_qr_step.sv
// One quarter-round step: a shared adder, xor and rotator on four words.
// Depends on csk_pkg for the control struct, mod31 and rotl.
module csk_qr_step
  import csk_pkg::*;
(
  input  qr_ctl_t   ctl_i,
  input  qr_words_t words_i,
  output qr_words_t words_o
);

  logic [4:0]       rot_amt;
  logic [WordW-1:0] add_x;
  logic [WordW-1:0] add_y;
  logic [WordW-1:0] other;
  logic [WordW-1:0] sum;
  logic [WordW-1:0] mix;

  // Rotation amount: data dependent on the first step, fixed otherwise.
  always_comb begin
    case (ctl_i.rot)
      ROT_DYN: rot_amt = mod31(words_i.c[7:0] ^ words_i.b[7:0]) + 5'd1;
      ROT_12:  rot_amt = 5'(RotB);
      ROT_8:   rot_amt = 5'(RotC);
      ROT_7:   rot_amt = 5'(RotD);
      default: rot_amt = 5'd0;
    endcase
  end

  // Operand selection for the shared adder and the word it mixes into.
  always_comb begin
    if (ctl_i.op == OP_CB) begin
      add_x = words_i.c;
      add_y = words_i.d;
      other = words_i.b;
    end else begin
      add_x = words_i.a;
      add_y = words_i.b;
      other = words_i.d;
    end
  end

  assign sum = add_x + add_y;
  assign mix = rotl(other ^ sum, rot_amt);

  // Write the sum and the rotated word back into their places.
  always_comb begin
    words_o = words_i;
    case (ctl_i.op)
      OP_AD: begin
        words_o.a = sum;
        words_o.d = mix;
      end
      OP_CB: begin
        words_o.c = sum;
        words_o.b = mix;
      end
      default: words_o = words_i;
    endcase
  end

endmodule

>>> rtl/chacha8_state_dependent_keystream_unit.sv
// Top level of the keystream unit: config registers, micro-sequencer,
// state matrix and output register. Depends on csk_pkg, csk_qr_step and
// the assertion macro header.
`include "chacha8_state_dependent_keystream_unit_assert.svh"

// Each input beat with request set yields one 64-byte block as sixteen
// output beats, word 0 first; load_counter reloads the block counter from
// counter_start before the block, and also acts on a beat without request.
// A requested block runs from its input beat through the rounds (32
// quarter-rounds of four steps each through the single adder and rotator,
// plus one loop step per double round) and sixteen output beats at one word
// per cycle while the output side does not stall; only then can the next
// input beat be taken. A beat without request starts no rounds. Output
// stalls delay the block. The next input beat is taken while the last word
// still waits in the output register.
// Configuration is written through its own port, which is always ready.
module chacha8_state_dependent_keystream_unit
  import csk_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Request channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                request_i,
  input  logic                load_counter_i,
  // Keystream channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WordW-1:0]    keystream_word_o,
  output logic [WordIdxW-1:0] word_index_o,
  output logic                last_word_o
);

  logic [CfgDataW-1:0] cfg_q [NumCfgRegs];
  logic [CfgDataW-1:0] ctr_q, ctr_d;
  logic [CfgDataW-1:0] ctr_sel;
  logic [WordW-1:0]    work_q [4][4];
  logic [WordW-1:0]    work_d [4][4];
  logic [WordW-1:0]    mixed  [4][4];
  logic [WordW-1:0]    init_w [NumWords];
  logic [PcW-1:0]      pc_q, pc_d;
  logic [1:0]          rnd_q, rnd_d;
  logic [WordIdxW-1:0] widx_q, widx_d;

  logic                out_valid_q, out_valid_d;
  logic [WordW-1:0]    out_word_q, out_word_d;
  logic [WordIdxW-1:0] out_idx_q, out_idx_d;
  logic                out_last_q, out_last_d;

  ucode_t              uc;
  qr_ctl_t             qr_ctl;
  qr_words_t           qr_in;
  qr_words_t           qr_out;
  logic                in_fire;
  logic                out_free;
  logic                emit_fire;
  logic                emit_done;

  // Fetch the control word of the current step.
  assign uc = ucode_rom(pc_q);

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (uc.op == OP_WAIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit_fire   = (uc.op == OP_EMIT) && out_free;
  assign emit_done   = emit_fire && (widx_q == WordIdxLast);

  // Configuration registers; writes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfgRegs; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumCfgRegs))) begin
      cfg_q[cfg_index_i[CfgSelW-1:0]] <= cfg_data_i;
    end
  end

  // Input words of the block; the counter reload is seen by the same beat.
  assign ctr_sel = (in_fire && load_counter_i) ? cfg_q[RegCounterStart] : ctr_q;

  always_comb begin
    logic [CfgDataW-1:0] pair;
    for (int p = 0; p < NumPairs; p++) begin
      if (p == CounterPair) begin
        pair = ctr_sel;
      end else if (p == CounterPair + 1) begin
        pair = cfg_q[RegNonce];
      end else begin
        pair = cfg_q[p];
      end
      init_w[2*p]     = pair[WordW-1:0];
      init_w[2*p + 1] = pair[CfgDataW-1:WordW];
    end
  end

  // Quarter-round step on column 0 of the state matrix.
  assign qr_ctl = '{op: uc.op, rot: uc.rot};
  assign qr_in  = '{a: work_q[0][0], b: work_q[1][0], c: work_q[2][0], d: work_q[3][0]};

  csk_qr_step u_qr_step (
    .ctl_i   (qr_ctl),
    .words_i (qr_in),
    .words_o (qr_out)
  );

  // Sequencer: step counter, double-round counter, word counter, block counter.
  always_comb begin
    pc_d   = pc_q;
    rnd_d  = rnd_q;
    widx_d = widx_q;
    ctr_d  = ctr_q;
    case (uc.op)
      OP_WAIT: begin
        if (in_fire) begin
          ctr_d = ctr_sel;
          if (request_i) begin
            pc_d = pc_q + PcW'(1);
          end
        end
      end
      OP_AD, OP_CB: begin
        pc_d = pc_q + PcW'(1);
      end
      OP_LOOP: begin
        if (rnd_q != LastRound) begin
          rnd_d = rnd_q + 2'd1;
          pc_d  = uc.target;
        end else begin
          rnd_d = '0;
          pc_d  = pc_q + PcW'(1);
        end
      end
      OP_EMIT: begin
        if (emit_fire) begin
          widx_d = widx_q + WordIdxW'(1);
          if (emit_done) begin
            pc_d  = uc.target;
            ctr_d = ctr_q + CfgDataW'(1);
          end
        end
      end
      default: pc_d = PcWait;
    endcase
  end

  // State matrix: load on a request, else quarter-round step and row rotation on a step, hold otherwise.
  always_comb begin
    mixed       = work_q;
    mixed[0][0] = qr_out.a;
    mixed[1][0] = qr_out.b;
    mixed[2][0] = qr_out.c;
    mixed[3][0] = qr_out.d;
    work_d      = work_q;
    if (in_fire && request_i) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 4; j++) begin
          work_d[r][j] = init_w[4*r + j];
        end
      end
    end else if (uc.op == OP_AD || uc.op == OP_CB) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 4; j++) begin
          work_d[r][j] = mixed[r][2'(j) + row_shift_amt(uc.shift, 2'(r))];
        end
      end
    end
  end

  // Output register: add back the input word as the beat is formed.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
      out_word_d  = work_q[widx_q[3:2]][widx_q[1:0]] + init_w[widx_q];
      out_idx_d   = widx_q;
      out_last_d  = (widx_q == WordIdxLast);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcWait;
      rnd_q       <= '0;
      widx_q      <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      rnd_q       <= rnd_d;
      widx_q      <= widx_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign keystream_word_o = out_word_q;
  assign word_index_o     = out_idx_q;
  assign last_word_o      = out_last_q;

  // Checks on the sequencer and counters.
  `CSK_NEVER(a_wait_counters_clear, in_ready_o && (rnd_q != '0 || widx_q != '0), "counters not clear while waiting")
  `CSK_ASSERT(a_back_to_wait, emit_done |=> in_ready_o, "sequencer did not return to wait after last word")
  `CSK_ASSERT(a_ctr_stable, (!(in_fire && load_counter_i) && !emit_done) |=> $stable(ctr_q), "block counter moved outside reload or block end")
  `CSK_ASSERT(a_out_from_emit, $rose(out_valid_o) |-> $past(uc.op == OP_EMIT), "output beat raised outside the output step")

endmodule
